@@ sv/svs_pkg.sv @@
package svs_pkg;

  // command codes
  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_CLEAR    = 3'd2,
    CMD_SET_MAX  = 3'd3,
    CMD_SET_MIN  = 3'd4,
    CMD_NEAREST  = 3'd5,
    CMD_INDEX_OF = 3'd6,
    CMD_VALUE_AT = 3'd7
  } cmd_t;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_BAD_INDEX = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_VAL_RD,
    S_VAL_CHK,
    S_MIN_RD,
    S_MIN_CHK,
    S_MAX_CHK,
    S_DONE
  } seq_state_t;

endpackage

@@ sv/svs_mem.sv @@
module svs_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/sorted_value_set_snap.sv @@
// Sorted value set with nearest-value lookup.
// The input channel (in_valid / in_stall) carries one command transaction:
// cmd, key_value and slot_index. The output channel (out_valid / out_stall)
// returns exactly one result transaction per command: status, out_value,
// out_index, entry_count, least_value and greatest_value.
// The values sit in ascending order in a single-port-read, single-port-write
// memory with a registered read port, walked by a sequencer.
// One command is worked at a time; in_stall is high from acceptance until the
// result is loaded into the output register.
// Per command: a scan step for each entry below the key's sorted place, then
// for insert, remove and set_min a move step for each shifted entry, then the
// fetch of the end entries and the result load. Clear and value_at skip the
// scan. Each entry step makes one access to the memory read port.
// Reset empties the set and drops any pending result; the memory needs no
// clearing pass since only entries below the count are ever read.
// While the receiver stalls, the result is held in the output register and
// the next command may still be accepted and worked up to its final load.
module sorted_value_set_snap
  import svs_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   cmd,
  input  logic signed [VALUE_BITS-1:0] key_value,
  input  logic [$clog2(TABLE_DEPTH)-1:0] slot_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   status,
  output logic signed [VALUE_BITS-1:0] out_value,
  output logic [$clog2(TABLE_DEPTH)-1:0] out_index,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] entry_count,
  output logic signed [VALUE_BITS-1:0] least_value,
  output logic signed [VALUE_BITS-1:0] greatest_value
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int VB = VALUE_BITS;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  seq_state_t state, state_next;
  cmd_t cmd_r, cmd_r_next;
  logic signed [VB-1:0] key_r, key_r_next;
  logic [AW-1:0] slot_r, slot_r_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] shift_gap, shift_gap_next;
  logic found, found_next;
  logic signed [VB-1:0] prev, prev_next;
  logic signed [VB-1:0] cur, cur_next;
  logic [2:0] stat_r, stat_r_next;
  logic signed [VB-1:0] oval_r, oval_r_next;
  logic [AW-1:0] oidx_r, oidx_r_next;
  logic signed [VB-1:0] least_r, least_r_next;
  logic signed [VB-1:0] great_r, great_r_next;
  logic load_out;

  logic           wr_en, rd_en;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [VB-1:0]  wr_data, rd_raw;
  logic signed [VB-1:0] rd_data;

  logic [CW-1:0] idx_dec, idx_dst, cnt_dec, q_pos;
  logic [VB:0]   up_dist, lo_dist;

  assign rd_data = rd_raw;
  assign idx_dec = idx - 1'b1;
  assign idx_dst = idx - shift_gap;
  assign cnt_dec = cnt - 1'b1;
  assign q_pos   = pos + CW'(found);
  assign up_dist = {cur[VB-1], cur} - {key_r[VB-1], key_r};
  assign lo_dist = {key_r[VB-1], key_r} - {prev[VB-1], prev};

  svs_mem #(.DEPTH(TABLE_DEPTH), .WIDTH(VB), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign in_stall = (state != S_IDLE);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= load_out | (out_valid & out_stall);
    end
  end

  // working payload registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_r_next;
    key_r     <= key_r_next;
    slot_r    <= slot_r_next;
    idx       <= idx_next;
    pos       <= pos_next;
    shift_gap <= shift_gap_next;
    found     <= found_next;
    prev      <= prev_next;
    cur       <= cur_next;
    stat_r    <= stat_r_next;
    oval_r    <= oval_r_next;
    oidx_r    <= oidx_r_next;
    least_r   <= least_r_next;
    great_r   <= great_r_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      status         <= stat_r;
      out_value      <= oval_r;
      out_index      <= oidx_r;
      entry_count    <= cnt;
      least_value    <= least_r;
      greatest_value <= great_r;
    end
  end

  // sequencer
  always_comb begin
    state_next     = state;
    cmd_r_next     = cmd_r;
    key_r_next     = key_r;
    slot_r_next    = slot_r;
    cnt_next       = cnt;
    idx_next       = idx;
    pos_next       = pos;
    shift_gap_next = shift_gap;
    found_next     = found;
    prev_next      = prev;
    cur_next       = cur;
    stat_r_next    = stat_r;
    oval_r_next    = oval_r;
    oidx_r_next    = oidx_r;
    least_r_next   = least_r;
    great_r_next   = great_r;
    load_out       = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = idx[AW-1:0];
    wr_data        = key_r;
    rd_en          = 1'b0;
    rd_addr        = idx[AW-1:0];

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_r_next  = cmd_t'(cmd);
          key_r_next  = key_value;
          slot_r_next = slot_index;
          stat_r_next = ST_OK;
          oval_r_next = '0;
          oidx_r_next = '0;
          idx_next    = '0;
          found_next  = 1'b0;
          case (cmd_t'(cmd))
            CMD_CLEAR: begin
              cnt_next   = '0;
              state_next = S_MIN_RD;
            end
            CMD_VALUE_AT: state_next = S_VAL_RD;
            default:      state_next = S_SCAN_RD;
          endcase
        end
      end

      // linear search for the first entry not below the key
      S_SCAN_RD: begin
        if (idx >= cnt) begin
          pos_next   = cnt;
          state_next = S_DECIDE;
        end else begin
          rd_en      = 1'b1;
          state_next = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        if (rd_data >= key_r) begin
          pos_next   = idx;
          cur_next   = rd_data;
          found_next = (rd_data == key_r);
          state_next = S_DECIDE;
        end else begin
          prev_next  = rd_data;
          idx_next   = idx + 1'b1;
          state_next = S_SCAN_RD;
        end
      end

      // act on the search result
      S_DECIDE: begin
        state_next = S_MIN_RD;
        case (cmd_r)
          CMD_INSERT: begin
            if (found) begin
              stat_r_next = ST_NOT_FOUND;
            end else if (cnt >= DEPTH_C) begin
              stat_r_next = ST_FULL;
            end else begin
              idx_next   = cnt;
              state_next = S_UP_RD;
            end
          end
          CMD_REMOVE: begin
            if (!found) begin
              stat_r_next = ST_NOT_FOUND;
            end else begin
              idx_next       = pos + 1'b1;
              shift_gap_next = CW'(1);
              state_next     = S_DN_RD;
            end
          end
          CMD_SET_MAX: begin
            cnt_next = pos;
            if (pos >= DEPTH_C) begin
              stat_r_next = ST_FULL;
            end else begin
              wr_en    = 1'b1;
              wr_addr  = pos[AW-1:0];
              cnt_next = pos + 1'b1;
            end
          end
          CMD_SET_MIN: begin
            if (q_pos == '0) begin
              if (cnt >= DEPTH_C) begin
                stat_r_next = ST_FULL;
              end else begin
                idx_next   = cnt;
                state_next = S_UP_RD;
              end
            end else begin
              // key takes slot zero, the kept tail closes up behind it
              wr_en          = 1'b1;
              wr_addr        = '0;
              idx_next       = q_pos;
              shift_gap_next = q_pos - 1'b1;
              state_next     = S_DN_RD;
            end
          end
          CMD_NEAREST: begin
            if (cnt == '0) begin
              stat_r_next = ST_EMPTY;
            end else if (found) begin
              oval_r_next = key_r;
            end else if (pos == '0) begin
              oval_r_next = cur;
            end else if (pos >= cnt) begin
              oval_r_next = prev;
            end else begin
              oval_r_next = (up_dist > lo_dist) ? prev : cur;
            end
          end
          CMD_INDEX_OF: begin
            if (found) begin
              oidx_r_next = pos[AW-1:0];
            end else begin
              stat_r_next = ST_NOT_FOUND;
            end
          end
          default: ;
        endcase
      end

      // open a gap at pos, moving the tail up one place
      S_UP_RD: begin
        if (idx == pos) begin
          wr_en      = 1'b1;
          wr_addr    = pos[AW-1:0];
          cnt_next   = cnt + 1'b1;
          state_next = S_MIN_RD;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = idx_dec[AW-1:0];
          state_next = S_UP_WR;
        end
      end

      S_UP_WR: begin
        wr_en      = 1'b1;
        wr_addr    = idx[AW-1:0];
        wr_data    = rd_data;
        idx_next   = idx_dec;
        state_next = S_UP_RD;
      end

      // move the tail down by the gap
      S_DN_RD: begin
        if (idx >= cnt) begin
          cnt_next   = cnt - shift_gap;
          state_next = S_MIN_RD;
        end else begin
          rd_en      = 1'b1;
          state_next = S_DN_WR;
        end
      end

      S_DN_WR: begin
        wr_en      = 1'b1;
        wr_addr    = idx_dst[AW-1:0];
        wr_data    = rd_data;
        idx_next   = idx + 1'b1;
        state_next = S_DN_RD;
      end

      S_VAL_RD: begin
        if (cnt == '0) begin
          stat_r_next = ST_EMPTY;
          state_next  = S_MIN_RD;
        end else if (CW'(slot_r) >= cnt) begin
          stat_r_next = ST_BAD_INDEX;
          state_next  = S_MIN_RD;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = slot_r;
          state_next = S_VAL_CHK;
        end
      end

      S_VAL_CHK: begin
        oval_r_next = rd_data;
        state_next  = S_MIN_RD;
      end

      // fetch the end entries for the result
      S_MIN_RD: begin
        if (cnt == '0) begin
          least_r_next = '0;
          great_r_next = '0;
          state_next   = S_DONE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = '0;
          state_next = S_MIN_CHK;
        end
      end

      S_MIN_CHK: begin
        least_r_next = rd_data;
        rd_en        = 1'b1;
        rd_addr      = cnt_dec[AW-1:0];
        state_next   = S_MAX_CHK;
      end

      S_MAX_CHK: begin
        great_r_next = rd_data;
        state_next   = S_DONE;
      end

      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ sv/svs_chk.sv @@
module svs_chk #(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_BITS  = 32
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [$clog2(TABLE_DEPTH+1)-1:0] entry_count,
  input logic [VALUE_BITS-1:0]          least_value,
  input logic [VALUE_BITS-1:0]          greatest_value
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // one transaction at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a command is in work");

  // count never exceeds the table depth
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= ($clog2(TABLE_DEPTH+1))'(TABLE_DEPTH))
    else $error("entry count beyond depth");

  // ends of an empty set read zero
  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_count == '0 |-> least_value == '0 && greatest_value == '0)
    else $error("end values of empty set not zero");

  // a non-empty ordered set has least not above greatest
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_count != '0 |->
      $signed(least_value) <= $signed(greatest_value))
    else $error("least value above greatest value");

endmodule

bind sorted_value_set_snap svs_chk #(
  .TABLE_DEPTH (TABLE_DEPTH),
  .VALUE_BITS  (VALUE_BITS)
) u_svs_chk (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .entry_count    (entry_count),
  .least_value    (least_value),
  .greatest_value (greatest_value)
);

@@ verif/sorted_value_set_snap_tb.sv @@
module sorted_value_set_snap_tb;
  import svs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam longint CYCLE_LIMIT = 2000000;

  // one result transaction
  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] value;
    logic [5:0]         index;
    logic [6:0]         count;
    logic signed [31:0] least;
    logic signed [31:0] greatest;
  } set_result_t;

  // predicts each command against its own copy of the sorted table
  class set_scoreboard;
    logic signed [31:0] table_q[$];
    set_result_t        pending[$];
    int                 errors;

    function int lower_slot(logic signed [31:0] v);
      int i;
      i = 0;
      while (i < table_q.size() && table_q[i] < v) i++;
      return i;
    endfunction

    function logic [2:0] add_value(logic signed [31:0] v);
      int p;
      p = lower_slot(v);
      if (p < table_q.size() && table_q[p] == v) return ST_NOT_FOUND;
      if (table_q.size() >= DEPTH) return ST_FULL;
      table_q.insert(p, v);
      return ST_OK;
    endfunction

    function void note_command(cmd_t c, logic signed [31:0] v, logic [5:0] slot);
      set_result_t r;
      int p, n;
      logic signed [31:0] kept[$];
      longint ud, ld;
      r = '0;
      case (c)
        CMD_INSERT: r.status = add_value(v);
        CMD_REMOVE: begin
          p = lower_slot(v);
          if (p < table_q.size() && table_q[p] == v) table_q.delete(p);
          else r.status = ST_NOT_FOUND;
        end
        CMD_CLEAR: table_q.delete();
        CMD_SET_MAX: begin
          p = lower_slot(v);
          while (table_q.size() > p) void'(table_q.pop_back());
          r.status = add_value(v);
        end
        CMD_SET_MIN: begin
          foreach (table_q[i]) if (table_q[i] > v) kept.push_back(table_q[i]);
          table_q = kept;
          r.status = add_value(v);
        end
        CMD_NEAREST: begin
          n = table_q.size();
          if (n == 0) r.status = ST_EMPTY;
          else begin
            p = lower_slot(v);
            if (p < n && table_q[p] == v) r.value = v;
            else if (p == 0) r.value = table_q[0];
            else if (p >= n) r.value = table_q[n-1];
            else begin
              ud = longint'(table_q[p]) - longint'(v);
              ld = longint'(v) - longint'(table_q[p-1]);
              r.value = (ud > ld) ? table_q[p-1] : table_q[p];
            end
          end
        end
        CMD_INDEX_OF: begin
          p = lower_slot(v);
          if (p < table_q.size() && table_q[p] == v) r.index = p[5:0];
          else r.status = ST_NOT_FOUND;
        end
        default: begin
          if (table_q.size() == 0) r.status = ST_EMPTY;
          else if (slot >= table_q.size()) r.status = ST_BAD_INDEX;
          else r.value = table_q[slot];
        end
      endcase
      r.count = 7'(table_q.size());
      if (table_q.size() > 0) begin
        r.least = table_q[0];
        r.greatest = table_q[table_q.size()-1];
      end
      pending.push_back(r);
    endfunction

    function void check_result(set_result_t got);
      set_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result transaction %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.value !== exp.value) begin
        $display("%0t: out_value exp %0d got %0d", $time, exp.value, got.value);
        errors++;
      end
      if (got.index !== exp.index) begin
        $display("%0t: out_index exp %0d got %0d", $time, exp.index, got.index);
        errors++;
      end
      if (got.count !== exp.count) begin
        $display("%0t: entry_count exp %0d got %0d", $time, exp.count, got.count);
        errors++;
      end
      if (got.least !== exp.least) begin
        $display("%0t: least_value exp %0d got %0d", $time, exp.least, got.least);
        errors++;
      end
      if (got.greatest !== exp.greatest) begin
        $display("%0t: greatest_value exp %0d got %0d", $time, exp.greatest,
                 got.greatest);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] cmd = '0;
  logic signed [31:0] key_value = '0;
  logic [5:0] slot_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic signed [31:0] out_value;
  logic [5:0] out_index;
  logic [6:0] entry_count;
  logic signed [31:0] least_value, greatest_value;

  set_scoreboard sb = new();
  longint cycles = 0;
  bit quiet = 1'b0;
  logic signed [31:0] pool[16];

  sorted_value_set_snap #(.TABLE_DEPTH(64), .VALUE_BITS(32)) dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // cycle watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: check each accepted result, stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({status, out_value, out_index, entry_count, least_value,
                       greatest_value});
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 32);
  end

  // drive one command transaction, with a random gap before it unless quiet
  task automatic send_command(cmd_t c, logic signed [31:0] v, logic [5:0] slot);
    while (!quiet && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    key_value <= v;
    slot_index <= slot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(c, v, slot);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom();
      1: return pool[$urandom_range(15)];
      2: return pool[$urandom_range(15)] + $signed($urandom_range(4)) - 2;
      default: return $signed($urandom_range(40)) - 20;
    endcase
  endfunction

  initial begin
    cmd_t c;
    foreach (pool[i]) pool[i] = $urandom();
    pool[0] = 32'sh7fffffff;
    pool[1] = 32'sh80000000;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table cases, extremes, ties, duplicates
    send_command(CMD_NEAREST, 5, 0);
    send_command(CMD_VALUE_AT, 0, 0);
    send_command(CMD_REMOVE, 5, 0);
    send_command(CMD_INDEX_OF, 5, 0);
    send_command(CMD_INSERT, 32'sh7fffffff, 0);
    send_command(CMD_INSERT, 32'sh80000000, 0);
    send_command(CMD_INSERT, 32'sh80000000, 0);
    send_command(CMD_INSERT, 10, 0);
    send_command(CMD_INSERT, 20, 0);
    send_command(CMD_NEAREST, 15, 0);
    send_command(CMD_NEAREST, 14, 0);
    send_command(CMD_NEAREST, 0, 0);
    send_command(CMD_NEAREST, 20, 0);
    send_command(CMD_INDEX_OF, 20, 0);
    send_command(CMD_VALUE_AT, 0, 6'd63);
    send_command(CMD_VALUE_AT, 0, 6'd3);
    send_command(CMD_SET_MAX, 15, 0);
    send_command(CMD_SET_MIN, 0, 0);
    send_command(CMD_REMOVE, 15, 0);
    send_command(CMD_CLEAR, 0, 0);
    // fill to full then refuse
    quiet = 1'b1;
    for (int i = 0; i < DEPTH; i++) send_command(CMD_INSERT, i * 3, 0);
    send_command(CMD_INSERT, 1, 0);
    send_command(CMD_SET_MAX, 32'sh7fffffff, 0);
    send_command(CMD_SET_MIN, 32'sh80000000, 0);
    send_command(CMD_VALUE_AT, 0, 6'd63);
    quiet = 1'b0;
    drain();

    // random: inserts most often to grow the table, with every command mixed in
    for (int n = 0; n < 1450; n++) begin
      if (n >= 400 && n < 600) quiet = 1'b1;
      else quiet = 1'b0;
      if (n == 800) drain();
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6: c = CMD_INSERT;
        7, 8: c = CMD_REMOVE;
        9: c = ($urandom_range(5) == 0) ? CMD_CLEAR : CMD_INSERT;
        10: c = CMD_SET_MAX;
        11: c = CMD_SET_MIN;
        12, 13, 14: c = CMD_NEAREST;
        15, 16: c = CMD_INDEX_OF;
        default: c = CMD_VALUE_AT;
      endcase
      send_command(c, pick_value(), $urandom_range(63));
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
